FILE: sv/dq_pkg.sv
package dq_pkg;

  // Default geometry of the queue.
  localparam int DQ_DEPTH     = 16;
  localparam int DQ_ITEM_BITS = 32;

  // Widths of the channel fields.
  localparam int KIND_W    = 3;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // Request codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request that has issued to the slot store; rd marks one that waits for its read data.
  typedef struct packed {
    logic                 valid;
    logic                 rd;
    status_t              status;
    logic [ENTRIES_W-1:0] entries;
  } issue_t;

endpackage

FILE: sv/dq_req_if.sv
interface dq_req_if import dq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ITEM_W-1:0] item;

  modport source (output valid, output kind, output item, input ready);
  modport sink (input valid, input kind, input item, output ready);

endinterface

FILE: sv/dq_rsp_if.sv
interface dq_rsp_if import dq_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [ITEM_W-1:0]    out_item;
  logic [STATUS_W-1:0]  status;
  logic [ENTRIES_W-1:0] entries;

  modport source (output valid, output out_item, output status, output entries, input ready);
  modport sink (input valid, input out_item, input status, input entries, output ready);

endinterface

FILE: sv/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dq_ctrl.sv
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH    = DQ_DEPTH,
  parameter int STORE_W  = DQ_ITEM_BITS,
  parameter int AW       = $clog2(DEPTH),
  parameter int CW       = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [ITEM_W-1:0]  in_item,
  output logic               in_ready,
  input  logic               issue_take,
  output issue_t             issue,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [STORE_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr
);

  logic [AW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;
  issue_t          issue_r, issue_nxt;
  logic            in_fire;
  logic            full, empty;
  logic [AW-1:0]   front_dec, front_inc;
  logic [AW-1:0]   back_off;
  logic [AW:0]     back_sum;
  logic [AW-1:0]   back_idx;
  logic [CW-1:0]   occ_m1;
  status_t         status;
  logic            rd;

  // A beat enters when the issue slot is empty or drains this cycle.
  assign in_ready = !issue_r.valid || issue_take;
  assign in_fire  = in_valid && in_ready;

  assign full   = (occ_r == CW'(DEPTH));
  assign empty  = (occ_r == '0);
  assign occ_m1 = occ_r - CW'(1);

  // Ring neighbors of the front slot.
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - AW'(1);
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + AW'(1);

  // Back slot: the one past the last item for a push, the last item otherwise.
  assign back_off = (in_kind == KIND_PUSH_BACK) ? occ_r[AW-1:0] : occ_m1[AW-1:0];
  assign back_sum = {1'b0, front_r} + {1'b0, back_off};
  assign back_idx = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                 : back_sum[AW-1:0];

  assign ram_wdata = in_item[STORE_W-1:0];

  // Decode one request into store accesses and pointer updates.
  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    ram_we    = 1'b0;
    ram_waddr = front_dec;
    ram_re    = 1'b0;
    ram_raddr = front_r;
    status    = ST_DONE;
    rd        = 1'b0;
    if (in_fire) begin
      case (in_kind)
        KIND_PUSH_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            front_nxt = front_dec;
            occ_nxt   = occ_r + CW'(1);
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = back_idx;
            occ_nxt   = occ_r + CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd        = 1'b1;
            ram_raddr = front_r;
            front_nxt = front_inc;
            occ_nxt   = occ_m1;
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd        = 1'b1;
            ram_raddr = back_idx;
            occ_nxt   = occ_m1;
          end
        end
        KIND_PEEK_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd        = 1'b1;
            ram_raddr = front_r;
          end
        end
        KIND_PEEK_BACK: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd        = 1'b1;
            ram_raddr = back_idx;
          end
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  // Issue slot contents for the next cycle.
  always_comb begin
    issue_nxt = issue_r;
    if (in_fire) begin
      issue_nxt.valid   = 1'b1;
      issue_nxt.rd      = rd;
      issue_nxt.status  = status;
      issue_nxt.entries = ENTRIES_W'(occ_nxt);
    end else if (issue_take) begin
      issue_nxt.valid = 1'b0;
    end
  end

  // Pointer, count and issue slot registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
      issue_r <= '0;
    end else begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      issue_r <= issue_nxt;
    end
  end

  assign issue = issue_r;

  // The count never passes the store size.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  // The front pointer stays inside the ring.
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= AW'(DEPTH - 1))
    else $error("front pointer outside ring");

  // A request reads or writes the store, never both.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("read and write in one cycle");

  // A successful push grows the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !full && (in_kind == KIND_PUSH_FRONT || in_kind == KIND_PUSH_BACK))
    |=> occ_r == $past(occ_r) + CW'(1))
    else $error("push did not grow the count");

endmodule

FILE: sv/double_ended_queue.sv
// Double-ended queue of item words held in a ring of DEPTH slots.
// Request channel in_req: kind selects push front/back, pop front/back or
// peek front/back; item is the word to push (kept to min(ITEM_BITS, ITEM_W) bits).
// Result channel out_rsp: one beat per request with the item popped or
// peeked (zero otherwise), a status (done, empty, full) and the number of
// entries held after the request.
// An accepted request passes the issue register, alongside the slot store's
// registered read, and then the result register before its result beat.
// Throughput is one request per cycle while the receiver does not stall; the
// slot store has one write and one read port, and a request does at most one
// access, so consecutive requests never collide on an entry.
// Reset empties the queue at once: front pointer and count go to zero and
// no result is pending. Slot contents are not cleared.
// When the receiver stalls, the result register holds its beat, the next
// request waits in the issue stage, and in_req.ready drops until the
// result register frees up.
module double_ended_queue import dq_pkg::*; #(
  parameter int DEPTH     = DQ_DEPTH,
  parameter int ITEM_BITS = DQ_ITEM_BITS
) (
  input logic      clk,
  input logic      rst_n,
  dq_req_if.sink   in_req,
  dq_rsp_if.source out_rsp
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int STORE_W = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;

  issue_t               issue;
  logic                 issue_take;
  logic                 out_free;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [STORE_W-1:0]   ram_wdata, ram_rdata;
  logic                 out_valid_r, out_valid_nxt;
  logic [ITEM_W-1:0]    out_item_r, out_item_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ENTRIES_W-1:0] out_entries_r, out_entries_nxt;

  dq_ctrl #(
    .DEPTH   (DEPTH),
    .STORE_W (STORE_W),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_kind    (in_req.kind),
    .in_item    (in_req.item),
    .in_ready   (in_req.ready),
    .issue_take (issue_take),
    .issue      (issue),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  dq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The result register takes the issued request when it is empty or draining.
  assign out_free   = !out_valid_r || out_rsp.ready;
  assign issue_take = issue.valid && out_free;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_item_nxt    = out_item_r;
    out_status_nxt  = out_status_r;
    out_entries_nxt = out_entries_r;
    if (issue_take) begin
      out_valid_nxt   = 1'b1;
      out_item_nxt    = issue.rd ? ITEM_W'(ram_rdata) : '0;
      out_status_nxt  = issue.status;
      out_entries_nxt = issue.entries;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r    <= out_item_nxt;
    out_status_r  <= out_status_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.out_item = out_item_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.entries  = out_entries_r;

  // A request that reads the store always reports done.
  a_rd_done: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && issue.rd) |-> issue.status == ST_DONE)
    else $error("read request with error status");

  // An error result carries no item.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> out_item_r == '0)
    else $error("error result with item");

endmodule
